>>> rtl/core/lsra_pkg.sv
// ----------------------------------------------------------------------------
// Laser scan reactive avoidance: shared definitions
// Widths, reset values, register indexes and the structs passed between the
// configuration, accumulation and decision stages.
// ----------------------------------------------------------------------------
package lsra_pkg;

  // Field widths.
  localparam int RangeW   = 16;
  localparam int CountW   = 13;
  localparam int SumW     = 32;
  localparam int PctW     = 7;
  localparam int SpeedW   = 16;
  localparam int RateW    = 15;
  localparam int TurnW    = 16;
  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 16;
  localparam int ShareW   = CountW + PctW;

  // Default largest scan that is honoured.
  localparam int MaxScanDefault = 4096;

  // Counters saturate at their all-ones value.
  localparam logic [CountW-1:0] CountMax = '1;

  // An unknown sample adds minus 1000 to its half's sum.
  localparam logic [SumW-1:0] UnknownAdd = 32'hFFFF_FC18;

  // Percent scaling for the unknown-share test.
  localparam logic [ShareW-1:0] PercentScale = ShareW'(100);

  // Register reset values.
  localparam logic [RangeW-1:0] RangeMinReset     = 16'd100;
  localparam logic [RangeW-1:0] RangeMaxReset     = 16'd30000;
  localparam logic [RangeW-1:0] DangerMarginReset = 16'd150;
  localparam logic [PctW-1:0]   UnknownPctReset   = 7'd15;
  localparam logic [SpeedW-1:0] ForwardSpeedReset = 16'd150;
  localparam logic [RateW-1:0]  TurnRateReset     = 15'd87;
  localparam logic [CountW-1:0] ScanLengthReset   = 13'd360;

  // Configuration register indexes.
  typedef enum logic [CfgAddrW-1:0] {
    REG_RANGE_MIN     = 3'd0,
    REG_RANGE_MAX     = 3'd1,
    REG_DANGER_MARGIN = 3'd2,
    REG_UNKNOWN_PCT   = 3'd3,
    REG_FORWARD_SPEED = 3'd4,
    REG_TURN_RATE     = 3'd5,
    REG_SCAN_LENGTH   = 3'd6
  } cfg_reg_t;

  // Current configuration as seen by the datapath.
  typedef struct packed {
    logic [RangeW-1:0] range_min_mm;
    logic [RangeW-1:0] range_max_mm;
    logic [RangeW-1:0] danger_margin_mm;
    logic [PctW-1:0]   unknown_percent;
    logic [SpeedW-1:0] forward_speed;
    logic [RateW-1:0]  turn_rate;
    logic [CountW-1:0] scan_length;
  } lsra_cfg_t;

  // Totals of one finished scan.
  typedef struct packed {
    logic [SumW-1:0]   left_sum;
    logic [SumW-1:0]   right_sum;
    logic [CountW-1:0] unknown_count;
    logic [CountW-1:0] sample_count;
    logic              danger;
  } lsra_scan_t;

endpackage

>>> rtl/core/lsra_in_if.sv
// ----------------------------------------------------------------------------
// Laser scan reactive avoidance: sample channel
// One range sample per transaction, with a flag on the last sample of a scan.
// ----------------------------------------------------------------------------
interface lsra_in_if
  import lsra_pkg::*;
  ;
  logic              valid;
  logic              ready;
  logic [RangeW-1:0] range_mm;
  logic              last_sample;

  modport source (output valid, output range_mm, output last_sample, input ready);
  modport sink   (input valid, input range_mm, input last_sample, output ready);
endinterface

>>> rtl/core/lsra_out_if.sv
// ----------------------------------------------------------------------------
// Laser scan reactive avoidance: drive command channel
// One drive command per transaction, issued at the end of each scan.
// ----------------------------------------------------------------------------
interface lsra_out_if
  import lsra_pkg::*;
  ;
  logic                    valid;
  logic                    ready;
  logic [SpeedW-1:0]       speed_out;
  logic signed [TurnW-1:0] turn_out;
  logic                    obstacle;

  modport source (output valid, output speed_out, output turn_out, output obstacle,
                  input ready);
  modport sink   (input valid, input speed_out, input turn_out, input obstacle,
                  output ready);
endinterface

>>> rtl/core/lsra_cfg_if.sv
// ----------------------------------------------------------------------------
// Laser scan reactive avoidance: configuration write channel
// One register write per transaction: register index and write data.
// ----------------------------------------------------------------------------
interface lsra_cfg_if
  import lsra_pkg::*;
  ;
  logic                valid;
  logic                ready;
  logic [CfgAddrW-1:0] index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/lsra_cfg_regs.sv
// ----------------------------------------------------------------------------
// Laser scan reactive avoidance: configuration registers
// Holds the seven control registers; writes to unused indexes are dropped.
// ----------------------------------------------------------------------------
module lsra_cfg_regs
  import lsra_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  lsra_cfg_if.sink   cfg,
  output lsra_cfg_t  cfg_o
);

  lsra_cfg_t regs;

  // Writes are always taken.
  assign cfg.ready = 1'b1;
  assign cfg_o     = regs;

  // Register file with per-index write decode.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.range_min_mm     <= RangeMinReset;
      regs.range_max_mm     <= RangeMaxReset;
      regs.danger_margin_mm <= DangerMarginReset;
      regs.unknown_percent  <= UnknownPctReset;
      regs.forward_speed    <= ForwardSpeedReset;
      regs.turn_rate        <= TurnRateReset;
      regs.scan_length      <= ScanLengthReset;
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.index))
        REG_RANGE_MIN:     regs.range_min_mm     <= cfg.data;
        REG_RANGE_MAX:     regs.range_max_mm     <= cfg.data;
        REG_DANGER_MARGIN: regs.danger_margin_mm <= cfg.data;
        REG_UNKNOWN_PCT:   regs.unknown_percent  <= cfg.data[PctW-1:0];
        REG_FORWARD_SPEED: regs.forward_speed    <= cfg.data;
        REG_TURN_RATE:     regs.turn_rate        <= cfg.data[RateW-1:0];
        REG_SCAN_LENGTH:   regs.scan_length      <= cfg.data[CountW-1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/core/lsra_accum.sv
// ----------------------------------------------------------------------------
// Laser scan reactive avoidance: sample accumulator
// Registers each sample, classifies it and updates the per-scan sums and
// counters; on the last sample hands the scan totals to the decision stage.
// ----------------------------------------------------------------------------
module lsra_accum
  import lsra_pkg::*;
#(
  parameter int MAX_SCAN = MaxScanDefault
)(
  input  logic       clk,
  input  logic       rst,
  input  lsra_cfg_t  cfg_i,
  lsra_in_if.sink    sample_in,
  output logic       scan_valid,
  output lsra_scan_t scan,
  input  logic       scan_ready
);

  localparam logic [CountW:0] MaxScanW = (CountW + 1)'(MAX_SCAN);

  // Input register.
  logic              s1_valid;
  logic [RangeW-1:0] s1_range;
  logic              s1_last;
  logic              s1_go;

  // Scan accumulators.
  logic [CountW-1:0] sample_index;
  logic [SumW-1:0]   left_sum;
  logic [SumW-1:0]   right_sum;
  logic [CountW-1:0] unknown_count;
  logic              danger_seen;

  logic [CountW:0]   len_clamped;
  logic [CountW-1:0] half;
  logic              in_window;
  logic              near_hit;
  logic              in_left;
  logic [SumW-1:0]   add;
  logic [RangeW:0]   danger_limit;

  logic [SumW-1:0]   left_sum_next;
  logic [SumW-1:0]   right_sum_next;
  logic [CountW-1:0] unknown_count_next;
  logic [CountW-1:0] sample_index_next;
  logic              danger_seen_next;

  // A sample moves on unless it closes a scan and the summary slot is full.
  assign s1_go           = s1_valid && (!s1_last || scan_ready);
  assign sample_in.ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample_in.ready) begin
      s1_valid <= sample_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_in.ready && sample_in.valid) begin
      s1_range <= sample_in.range_mm;
      s1_last  <= sample_in.last_sample;
    end
  end

  // Sample classification and accumulator update.
  always_comb begin
    len_clamped  = ({1'b0, cfg_i.scan_length} > MaxScanW) ? MaxScanW
                                                          : {1'b0, cfg_i.scan_length};
    half         = len_clamped[CountW:1];
    in_window    = (s1_range >= cfg_i.range_min_mm) && (s1_range <= cfg_i.range_max_mm);
    danger_limit = {1'b0, cfg_i.range_min_mm} + {1'b0, cfg_i.danger_margin_mm};
    near_hit     = in_window && ({1'b0, s1_range} <= danger_limit);
    in_left      = sample_index < half;
    add          = in_window ? {{(SumW - RangeW){1'b0}}, s1_range} : UnknownAdd;

    left_sum_next  = in_left ? left_sum + add : left_sum;
    right_sum_next = in_left ? right_sum : right_sum + add;

    unknown_count_next = unknown_count;
    if (!in_window && (unknown_count != CountMax)) begin
      unknown_count_next = unknown_count + 1'b1;
    end

    sample_index_next = sample_index;
    if (sample_index != CountMax) begin
      sample_index_next = sample_index + 1'b1;
    end

    danger_seen_next = danger_seen || near_hit;
  end

  // Totals offered to the decision stage on the last sample.
  assign scan_valid         = s1_valid && s1_last;
  assign scan.left_sum      = left_sum_next;
  assign scan.right_sum     = right_sum_next;
  assign scan.unknown_count = unknown_count_next;
  assign scan.sample_count  = sample_index_next;
  assign scan.danger        = danger_seen_next;

  // Accumulators restart after the last sample of a scan.
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index  <= '0;
      left_sum      <= '0;
      right_sum     <= '0;
      unknown_count <= '0;
      danger_seen   <= 1'b0;
    end else if (s1_go) begin
      if (s1_last) begin
        sample_index  <= '0;
        left_sum      <= '0;
        right_sum     <= '0;
        unknown_count <= '0;
        danger_seen   <= 1'b0;
      end else begin
        sample_index  <= sample_index_next;
        left_sum      <= left_sum_next;
        right_sum     <= right_sum_next;
        unknown_count <= unknown_count_next;
        danger_seen   <= danger_seen_next;
      end
    end
  end

endmodule

>>> rtl/core/lsra_decide.sv
// ----------------------------------------------------------------------------
// Laser scan reactive avoidance: drive decision
// Registers the totals of a finished scan, applies the unknown-share test,
// keeps the rotation lock and fills the command output register.
// ----------------------------------------------------------------------------
module lsra_decide
  import lsra_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  lsra_cfg_t  cfg_i,
  input  logic       scan_valid,
  input  lsra_scan_t scan,
  output logic       scan_ready,
  lsra_out_if.source cmd_out
);

  logic       s2_valid;
  lsra_scan_t s2;
  logic       out_free;
  logic       s2_move;

  // Rotation lock state.
  logic rotation_locked;
  logic held_turn_negative;

  logic [ShareW-1:0]       unknown_scaled;
  logic [ShareW-1:0]       percent_scaled;
  logic                    danger;
  logic                    left_lower;
  logic                    turn_negative;
  logic signed [TurnW-1:0] turn_val;

  // Stage handshake: the output register frees when empty or taken.
  assign out_free   = !cmd_out.valid || cmd_out.ready;
  assign s2_move    = s2_valid && out_free;
  assign scan_ready = !s2_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (scan_ready) begin
      s2_valid <= scan_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_ready && scan_valid) begin
      s2 <= scan;
    end
  end

  // Danger decision and turn sign.
  always_comb begin
    unknown_scaled = ShareW'(s2.unknown_count) * PercentScale;
    percent_scaled = ShareW'(cfg_i.unknown_percent) * ShareW'(s2.sample_count);
    danger         = s2.danger || (unknown_scaled >= percent_scaled);
    left_lower     = $signed(s2.left_sum) < $signed(s2.right_sum);
    turn_negative  = rotation_locked ? held_turn_negative : !left_lower;
    turn_val       = turn_negative ? $signed(TurnW'(0) - {1'b0, cfg_i.turn_rate})
                                   : $signed({1'b0, cfg_i.turn_rate});
  end

  // Output register and rotation lock.
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_out.valid      <= 1'b0;
      rotation_locked    <= 1'b0;
      held_turn_negative <= 1'b0;
    end else begin
      if (out_free) begin
        cmd_out.valid <= s2_valid;
      end
      if (s2_move) begin
        if (danger) begin
          rotation_locked    <= 1'b1;
          held_turn_negative <= turn_negative;
        end else begin
          rotation_locked <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_move) begin
      cmd_out.speed_out <= danger ? '0 : cfg_i.forward_speed;
      cmd_out.turn_out  <= danger ? turn_val : '0;
      cmd_out.obstacle  <= danger;
    end
  end

endmodule

>>> rtl/core/laser_scan_reactive_avoidance_unit.sv
// ----------------------------------------------------------------------------
// Laser scan reactive avoidance unit
// Streams laser range samples of a scan and issues one drive command per scan.
// ----------------------------------------------------------------------------
// Usage:
//   sample_in carries one range reading in millimetres per transaction, with
//   last_sample set on the final reading of a scan. cmd_out carries one drive
//   command (speed, signed turn rate, obstacle flag) per scan. cfg writes the
//   seven control registers by index; it is always ready and should only be
//   used while no scan is in flight.
// Throughput: one sample per cycle while the input is not stalled (see Stalls),
//   with the add and compare of the accumulator stage done combinationally.
// Path: the command for a scan becomes valid once its last sample has passed
//   the input register, the scan summary register and the output register in
//   turn; a held cmd_out can stall it in any of them.
// Reset: rst is synchronous; it restores the register defaults, clears the
//   scan accumulators and the rotation lock, and empties the pipeline.
// Stalls: while cmd_out is held, samples that do not close a scan keep
//   flowing; one finished scan can wait behind the held command, and only a
//   further closing sample stops the input.
// ----------------------------------------------------------------------------
module laser_scan_reactive_avoidance_unit
  import lsra_pkg::*;
#(
  parameter int MAX_SCAN = MaxScanDefault
)(
  input  logic       clk,
  input  logic       rst,
  lsra_in_if.sink    sample_in,
  lsra_out_if.source cmd_out,
  lsra_cfg_if.sink   cfg
);

  lsra_cfg_t  cfg_q;
  logic       scan_valid;
  logic       scan_ready;
  lsra_scan_t scan;

  // Control registers.
  lsra_cfg_regs u_cfg_regs (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .cfg_o (cfg_q)
  );

  // Per-sample accumulation.
  lsra_accum #(
    .MAX_SCAN (MAX_SCAN)
  ) u_accum (
    .clk        (clk),
    .rst        (rst),
    .cfg_i      (cfg_q),
    .sample_in  (sample_in),
    .scan_valid (scan_valid),
    .scan       (scan),
    .scan_ready (scan_ready)
  );

  // End-of-scan decision.
  lsra_decide u_decide (
    .clk        (clk),
    .rst        (rst),
    .cfg_i      (cfg_q),
    .scan_valid (scan_valid),
    .scan       (scan),
    .scan_ready (scan_ready),
    .cmd_out    (cmd_out)
  );

  // A dangerous scan never commands forward motion.
  a_obstacle_stops : assert property (@(posedge clk) disable iff (rst)
    (cmd_out.valid && cmd_out.obstacle) |-> (cmd_out.speed_out == '0))
    else $error("obstacle command with nonzero speed");

  // A clear scan never commands a turn.
  a_clear_no_turn : assert property (@(posedge clk) disable iff (rst)
    (cmd_out.valid && !cmd_out.obstacle) |-> (cmd_out.turn_out == '0))
    else $error("clear command with nonzero turn");

  // Reset empties the output register.
  a_reset_empties : assert property (@(posedge clk)
    rst |=> !cmd_out.valid)
    else $error("command valid after reset");

endmodule
